### sv/hst_pkg.sv
// Package of shared types and constants for the hashed slot table.
`default_nettype none
package hst_pkg;

	// Hash accumulator: djb2, 64-bit wrap.
	localparam int            HASH_W     = 64;
	localparam int            HASH_CNT_W = 6;
	localparam int            HASH_SHIFT = 5;
	localparam logic [63:0]   HASH_START = 64'd5381;

	// Field widths of the stream beats.
	localparam int CMD_W      = 3;
	localparam int KEY_W      = 8;
	localparam int WORD_W     = 32;
	localparam int SLOT_OUT_W = 10;
	localparam int COUNT_OUT_W = 11;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;

	// Configuration port.
	localparam int          ADDR_W              = 3;
	localparam int          TSIZE_W             = 11;
	localparam logic [2:0]  CFG_TABLE_SIZE_ADDR = 3'd0;
	localparam logic [10:0] TABLE_SIZE_RESET    = 11'd1024;

	typedef enum logic [2:0] {
		CMD_GET          = 3'd0,
		CMD_CONTAINS_KEY = 3'd1,
		CMD_POP_KEY      = 3'd2,
		CMD_CONTAINS_VAL = 3'd3,
		CMD_POP_VAL      = 3'd4,
		CMD_PUT          = 3'd5
	} cmd_t;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_DIV    = 7'b0000100,
		ST_READ   = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_SCAN   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

endpackage
`default_nettype wire

### sv/hst_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
`default_nettype none
module hst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/hashed_slot_table.sv
// Top level of the hashed slot table: key hashing, remainder unit, slot RAM and scan.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       tdata: cmd, key_byte, value_word; tlast: key_last
// m_*       out        m_tvalid / m_tready       tdata: result_value, slot_index, element_count;
//                                                tuser: found
// APB       in/out     psel, penable, pready=1   table_size at byte address 0
//
// A key byte that is not the last one only updates the hash. The last key byte of a key
// command starts the remainder of the 64-bit hash by the table size, worked out one hash
// bit per cycle, then a RAM read, an update step that may write back, and a step that
// loads the output register once it is free.
// A value command with a nonzero word reads the slot RAM one entry per cycle until a match
// or the table end; a zero word is not looked up. After reset, a clearing pass writes
// zero to all SLOTS entries, one per cycle, while s_tready stays low. A finished result
// sits in the output register, so the next beat is accepted while it waits; a further
// result waits until that register is free.
`default_nettype none
module hashed_slot_table
	import hst_pkg::*;
#(
	parameter int SLOTS      = 1024,
	parameter int VALUE_BITS = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// Input stream.
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire [IN_DATA_W-1:0]    s_tdata,   // cmd[2:0], key_byte[10:3], value_word[42:11]
	input  wire                    s_tlast,   // key_last
	// Result stream.
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // result_value[31:0], slot_index[41:32],
	                                          // element_count[52:42]
	output logic                   m_tuser,   // found
	// Configuration port.
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire [ADDR_W-1:0]       paddr,
	input  wire [31:0]             pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// Unpacked input fields.
	cmd_t                  in_cmd;
	logic [KEY_W-1:0]      in_key;
	logic [WORD_W-1:0]     in_word;
	logic [VALUE_BITS-1:0] in_val;

	assign in_cmd  = cmd_t'(s_tdata[2:0]);
	assign in_key  = s_tdata[10:3];
	assign in_word = s_tdata[42:11];
	assign in_val  = VALUE_BITS'(in_word);

	state_t                 state_q;
	logic [TSIZE_W-1:0]     table_size_q;
	logic [HASH_W-1:0]      hash_q;
	logic [HASH_W-1:0]      div_q;
	logic [HASH_CNT_W-1:0]  div_cnt_q;
	logic [CNT_W-1:0]       rem_q;
	logic [CNT_W-1:0]       size_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       scan_addr_q;
	logic [SLOT_W-1:0]      clr_addr_q;
	logic                   chk_s1;
	logic [SLOT_W-1:0]      chk_idx_s1;
	cmd_t                   cmd_q;
	logic [VALUE_BITS-1:0]  val_q;

	// Pending result, moved to the output register in the finish state.
	logic                   res_found_q;
	logic [WORD_W-1:0]      res_value_q;
	logic [SLOT_W-1:0]      res_slot_q;

	logic                   out_valid_q;
	logic                   out_found_q;
	logic [OUT_DATA_W-1:0]  out_data_q;

	// Slot RAM port signals.
	logic                   ram_we;
	logic [SLOT_W-1:0]      ram_waddr;
	logic [VALUE_BITS-1:0]  ram_wdata;
	logic                   ram_re;
	logic [SLOT_W-1:0]      ram_raddr;
	logic [VALUE_BITS-1:0]  ram_rdata;

	hst_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration port: pready is always high, so a write lands on the access cycle.
	logic cfg_write;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr == CFG_TABLE_SIZE_ADDR) ? 32'(table_size_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RESET;
		end else if (cfg_write && paddr == CFG_TABLE_SIZE_ADDR) begin
			table_size_q <= pwdata[TSIZE_W-1:0];
		end
	end

	// Size in use: zero acts as one, anything above the RAM depth as the depth.
	logic [CNT_W-1:0] active_size;
	always_comb begin
		if (table_size_q == '0) begin
			active_size = CNT_W'(1);
		end else if (32'(table_size_q) > SLOTS) begin
			active_size = CNT_W'(SLOTS);
		end else begin
			active_size = CNT_W'(table_size_q);
		end
	end

	// One djb2 step: hash * 33 + sign-extended byte; a zero byte leaves the hash alone.
	logic [HASH_W-1:0] key_ext;
	logic [HASH_W-1:0] hash_nxt;
	assign key_ext  = {{(HASH_W - KEY_W){in_key[KEY_W-1]}}, in_key};
	assign hash_nxt = (in_key != '0) ? (hash_q << HASH_SHIFT) + hash_q + key_ext : hash_q;

	// Restoring remainder step, one dividend bit per cycle.
	logic [CNT_W:0]   rem_shift;
	logic             rem_ge;
	logic [CNT_W-1:0] rem_nxt;
	assign rem_shift = {rem_q, div_q[HASH_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, size_q};
	assign rem_nxt   = rem_ge ? CNT_W'(rem_shift - {1'b0, size_q}) : CNT_W'(rem_shift);

	// Scan: until a hit or the table end a read is issued each cycle, checked in the next
	// cycle. The first hit stops further reads, so the registered read data still holds the match.
	logic scan_hit;
	logic scan_issue;
	assign scan_hit   = chk_s1 && (ram_rdata == val_q);
	assign scan_issue = (state_q == ST_SCAN) && !scan_hit && (scan_addr_q < size_q);

	logic [SLOT_W-1:0] key_slot;
	logic              old_full;
	logic              out_free;
	logic              in_fire;
	assign key_slot = rem_q[SLOT_W-1:0];
	assign old_full = ram_rdata != '0;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = state_q == ST_IDLE;
	assign in_fire  = s_tvalid && s_tready;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = key_slot;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = key_slot;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_UPDATE: begin
				if (cmd_q == CMD_POP_KEY && old_full) begin
					ram_we = 1'b1;
				end else if (cmd_q == CMD_PUT && val_q != '0) begin
					ram_we    = 1'b1;
					ram_wdata = val_q;
				end
			end
			ST_SCAN: begin
				ram_re    = scan_issue;
				ram_raddr = scan_addr_q[SLOT_W-1:0];
				ram_waddr = chk_idx_s1;
				ram_we    = scan_hit && cmd_q == CMD_POP_VAL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			hash_q      <= HASH_START;
			count_q     <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the finish state the output register is reloaded instead.
			if (out_valid_q && m_tready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q  <= in_cmd;
						val_q  <= in_val;
						size_q <= active_size;
						case (in_cmd)
							CMD_GET, CMD_CONTAINS_KEY, CMD_POP_KEY, CMD_PUT: begin
								if (s_tlast) begin
									hash_q    <= HASH_START;
									div_q     <= hash_nxt;
									rem_q     <= '0;
									div_cnt_q <= '0;
									state_q   <= ST_DIV;
								end else begin
									hash_q <= hash_nxt;
								end
							end
							CMD_CONTAINS_VAL, CMD_POP_VAL: begin
								if (in_val == '0) begin
									res_found_q <= 1'b0;
									res_value_q <= '0;
									res_slot_q  <= '0;
									state_q     <= ST_FINISH;
								end else begin
									scan_addr_q <= '0;
									chk_s1      <= 1'b0;
									state_q     <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q     <= rem_nxt;
					div_q     <= div_q << 1;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == HASH_CNT_W'(HASH_W - 1)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					res_found_q <= old_full;
					res_value_q <= WORD_W'(ram_rdata);
					res_slot_q  <= key_slot;
					if (cmd_q == CMD_POP_KEY && old_full && count_q != '0) begin
						count_q <= count_q - 1'b1;
					end else if (cmd_q == CMD_PUT && val_q != '0 && !old_full) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_SCAN: begin
					chk_s1     <= scan_issue;
					chk_idx_s1 <= scan_addr_q[SLOT_W-1:0];
					if (scan_issue) begin
						scan_addr_q <= scan_addr_q + 1'b1;
					end
					if (scan_hit) begin
						res_found_q <= 1'b1;
						res_value_q <= WORD_W'(val_q);
						res_slot_q  <= chk_idx_s1;
						if (cmd_q == CMD_POP_VAL && count_q != '0) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= ST_FINISH;
					end else if (!scan_issue && !chk_s1) begin
						res_found_q <= 1'b0;
						res_value_q <= '0;
						res_slot_q  <= '0;
						state_q     <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_data_q  <= {3'b000, COUNT_OUT_W'(count_q),
						                SLOT_OUT_W'(res_slot_q), res_value_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

endmodule
`default_nettype wire

### sv/hst_check.sv
// Port-level checker for the hashed slot table, bound to the top level.
`default_nettype none
module hst_check
	import hst_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tready,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [OUT_DATA_W-1:0]  m_tdata,
	input wire                   m_tuser
);

	// A sampled reset leaves the clearing pass keeping the input closed with no result shown.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !s_tready && !m_tvalid)
		else $error("input open or result shown after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A miss never reports a word, a hit always reports a nonzero word.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("miss with nonzero value");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] != 32'd0)
		else $error("hit with zero value");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (SLOTS > 2047) || (32'(m_tdata[52:42]) <= SLOTS))
		else $error("element count above table depth");

endmodule

bind hashed_slot_table hst_check #(.SLOTS(SLOTS)) u_hst_check (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire
